// File: rtl/rwcl_pkg.sv
// Shared types and constants for the RIFF/WAVE data chunk locator.
// No dependencies; used by every module of the block.
package rwcl_pkg;

   localparam int unsigned LEN_W  = 31;
   localparam int unsigned TAG_W  = 32;
   localparam int unsigned SKIP_W = 33;

   localparam logic [TAG_W-1:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [TAG_W-1:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [TAG_W-1:0] TAG_DATA = 32'h6461_7461;

   localparam logic [LEN_W-1:0] MIN_FILE_LEN = 31'd44;
   localparam logic [LEN_W-1:0] WALK_START   = 31'd12;
   localparam logic [LEN_W-1:0] CHUNK_HDR    = 31'd8;
   localparam logic [LEN_W-1:0] FIRST_HDR_END = WALK_START + CHUNK_HDR;

   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_TAG,
      PHASE_SKIP,
      PHASE_DONE
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_FOUND,
      STATUS_SHORT,
      STATUS_NOT_WAVE,
      STATUS_NO_DATA
   } status_type;

   typedef struct packed {
      status_type       status;
      logic [LEN_W-1:0] data_offset;
      logic [LEN_W-1:0] data_size;
   } result_type;

endpackage

// File: rtl/riff_wave_data_chunk_locator_unit.sv
// Top level of the RIFF/WAVE data chunk locator: length register and wiring.
// Depends on rwcl_pkg, rwcl_parser and rwcl_frame_stage.
//
// Usage:
//   Write the file's byte length on csr_ (always ready) before the file, then
//   stream the file one byte per req_ transfer, marking byte 0 with
//   req_first_byte and the final byte with req_last_byte.
//   Exactly one rsp_ transfer comes per file: status, offset of the first PCM
//   byte, PCM size clamped to the file length, and the frame count.
//   Bytes after the decision are dropped until the next req_first_byte.
// Throughput: one byte per cycle while req_ready is high; each byte passes one
//   register of compare and add logic.
// Output path: a deciding byte's result goes into the decision register, then
//   through the frame count multiply into the output register on rsp_.
// Reset: clears the length to zero and starts a file at the next byte.
// Stall: a held rsp_ result leaves one more result slot free; bytes that
//   decide nothing keep flowing, and req_ready drops only when both
//   result registers are full.
module riff_wave_data_chunk_locator_unit #(
   parameter int FRAME_CHANNELS = 2,
   parameter int SAMPLE_BYTES   = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rwcl_pkg::LEN_W-1:0] csr_file_length,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_first_byte,
   input  logic                       req_last_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic [rwcl_pkg::LEN_W-1:0] rsp_data_offset,
   output logic [rwcl_pkg::LEN_W-1:0] rsp_data_size,
   output logic [rwcl_pkg::LEN_W-1:0] rsp_frame_count
);

   logic [rwcl_pkg::LEN_W-1:0] file_length_ff;
   logic                       res_valid;
   logic                       res_ready;
   rwcl_pkg::result_type       res_result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         file_length_ff <= csr_file_length;
      end
   end

   rwcl_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .req_last_byte  (req_last_byte),
      .file_length    (file_length_ff),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res_result     (res_result)
   );

   rwcl_frame_stage #(
      .FRAME_CHANNELS (FRAME_CHANNELS),
      .SAMPLE_BYTES   (SAMPLE_BYTES)
   ) u_frame_stage (
      .clock           (clock),
      .reset           (reset),
      .res_valid       (res_valid),
      .res_ready       (res_ready),
      .res_result      (res_result),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_data_offset (rsp_data_offset),
      .rsp_data_size   (rsp_data_size),
      .rsp_frame_count (rsp_frame_count)
   );

endmodule

// File: rtl/rwcl_parser.sv
// Byte-serial chunk walker: parse state, decision logic and a result register.
// Depends on rwcl_pkg.
module rwcl_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_first_byte,
   input  logic                           req_last_byte,
   input  logic [rwcl_pkg::LEN_W-1:0]     file_length,
   output logic                           res_valid,
   input  logic                           res_ready,
   output rwcl_pkg::result_type           res_result
);

   rwcl_pkg::phase_type               phase_ff, phase_in;
   logic [rwcl_pkg::TAG_W-1:0]        nxt_ff, nxt_in;
   logic [rwcl_pkg::TAG_W-1:0]        hdr_ff, hdr_in;
   logic [rwcl_pkg::TAG_W-1:0]        tag_ff, tag_in;
   logic [23:0]                       size_ff, size_in;
   logic [rwcl_pkg::SKIP_W-1:0]       skip_ff, skip_in;
   logic [2:0]                        idx_ff, idx_in;
   logic                              s1_valid_ff, s1_valid_in;
   rwcl_pkg::result_type              s1_result_ff, s1_result_in;

   logic                              accept;
   logic                              hit;

   assign req_ready = !s1_valid_ff || res_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      rwcl_pkg::phase_type         cur_phase;
      logic [rwcl_pkg::TAG_W-1:0]  cur_nxt;
      logic [rwcl_pkg::TAG_W-1:0]  cur_hdr;
      logic [rwcl_pkg::TAG_W-1:0]  cur_tag;
      logic [23:0]                 cur_size;
      logic [rwcl_pkg::SKIP_W-1:0] cur_skip;
      logic [2:0]                  cur_idx;
      logic [rwcl_pkg::TAG_W-1:0]  tag_new;
      logic [31:0]                 full_size;
      logic                        odd;
      logic [32:0]                 chunk_end;
      logic                        room_ok;
      logic [rwcl_pkg::LEN_W-1:0]  room;
      logic [rwcl_pkg::LEN_W-1:0]  clamped;

      cur_phase = phase_ff;
      cur_nxt   = nxt_ff;
      cur_hdr   = hdr_ff;
      cur_tag   = tag_ff;
      cur_size  = size_ff;
      cur_skip  = skip_ff;
      cur_idx   = idx_ff;
      if (req_first_byte) begin
         cur_phase = rwcl_pkg::PHASE_HEADER;
         cur_nxt   = 32'd1;
         cur_hdr   = 32'(rwcl_pkg::CHUNK_HDR) + 32'd1;
         cur_tag   = '0;
         cur_size  = '0;
         cur_skip  = '0;
         cur_idx   = '0;
      end

      tag_new   = {cur_tag[23:0], req_data_byte};
      full_size = {req_data_byte, cur_size};
      odd       = full_size[0];
      chunk_end = {1'b0, cur_hdr} + {1'b0, full_size} + {32'd0, odd};
      room_ok   = cur_nxt <= {1'b0, file_length};
      room      = file_length - cur_nxt[rwcl_pkg::LEN_W-1:0];
      if (!room_ok) begin
         clamped = '0;
      end else if (full_size > {1'b0, room}) begin
         clamped = room;
      end else begin
         clamped = full_size[rwcl_pkg::LEN_W-1:0];
      end

      phase_in = cur_phase;
      nxt_in   = cur_nxt;
      hdr_in   = cur_hdr;
      tag_in   = cur_tag;
      size_in  = cur_size;
      skip_in  = cur_skip;
      idx_in   = cur_idx;
      hit      = 1'b0;
      s1_result_in.status      = rwcl_pkg::STATUS_NO_DATA;
      s1_result_in.data_offset = '0;
      s1_result_in.data_size   = '0;

      if (cur_phase != rwcl_pkg::PHASE_DONE) begin
         if (cur_nxt == 32'h8000_0000) begin
            nxt_in = 32'd1;
            hdr_in = 32'(rwcl_pkg::CHUNK_HDR) + 32'd1;
         end else begin
            nxt_in = cur_nxt + 32'd1;
            hdr_in = cur_hdr + 32'd1;
         end
      end

      unique case (cur_phase)
         rwcl_pkg::PHASE_HEADER: begin
            tag_in = tag_new;
            if (cur_nxt == 32'd1 && file_length < rwcl_pkg::MIN_FILE_LEN) begin
               hit = 1'b1;
               s1_result_in.status = rwcl_pkg::STATUS_SHORT;
            end else if (cur_nxt == 32'd4 && tag_new != rwcl_pkg::TAG_RIFF) begin
               hit = 1'b1;
               s1_result_in.status = rwcl_pkg::STATUS_NOT_WAVE;
            end else if (cur_nxt == 32'(rwcl_pkg::WALK_START)) begin
               if (tag_new != rwcl_pkg::TAG_WAVE) begin
                  hit = 1'b1;
                  s1_result_in.status = rwcl_pkg::STATUS_NOT_WAVE;
               end else if (file_length < rwcl_pkg::FIRST_HDR_END) begin
                  hit = 1'b1;
                  s1_result_in.status = rwcl_pkg::STATUS_NO_DATA;
               end else begin
                  phase_in = rwcl_pkg::PHASE_TAG;
                  idx_in   = '0;
                  tag_in   = '0;
                  size_in  = '0;
                  if (req_last_byte) begin
                     hit = 1'b1;
                     s1_result_in.status = rwcl_pkg::STATUS_NO_DATA;
                  end
               end
            end else if (req_last_byte) begin
               hit = 1'b1;
               s1_result_in.status = rwcl_pkg::STATUS_NOT_WAVE;
            end
         end
         rwcl_pkg::PHASE_TAG: begin
            if (!cur_idx[2]) begin
               tag_in = tag_new;
            end else begin
               unique case (cur_idx[1:0])
                  2'd0:    size_in[7:0]   = req_data_byte;
                  2'd1:    size_in[15:8]  = req_data_byte;
                  2'd2:    size_in[23:16] = req_data_byte;
                  default: size_in        = cur_size;
               endcase
            end
            if (cur_idx == 3'd7) begin
               if (cur_tag == rwcl_pkg::TAG_DATA) begin
                  hit = 1'b1;
                  s1_result_in.status      = rwcl_pkg::STATUS_FOUND;
                  s1_result_in.data_offset = cur_nxt[rwcl_pkg::LEN_W-1:0];
                  s1_result_in.data_size   = clamped;
               end else if (chunk_end > {2'b00, file_length}) begin
                  hit = 1'b1;
                  s1_result_in.status = rwcl_pkg::STATUS_NO_DATA;
               end else begin
                  idx_in  = '0;
                  tag_in  = '0;
                  size_in = '0;
                  skip_in = {1'b0, full_size} + {32'd0, odd};
                  phase_in = (full_size == '0) ? rwcl_pkg::PHASE_TAG
                                               : rwcl_pkg::PHASE_SKIP;
                  if (req_last_byte) begin
                     hit = 1'b1;
                     s1_result_in.status = rwcl_pkg::STATUS_NO_DATA;
                  end
               end
            end else begin
               idx_in = cur_idx + 3'd1;
               if (req_last_byte) begin
                  hit = 1'b1;
                  s1_result_in.status = rwcl_pkg::STATUS_NO_DATA;
               end
            end
         end
         rwcl_pkg::PHASE_SKIP: begin
            if (cur_skip != '0) begin
               skip_in = cur_skip - 33'd1;
            end
            if (cur_skip <= 33'd1) begin
               phase_in = rwcl_pkg::PHASE_TAG;
               idx_in   = '0;
               tag_in   = '0;
               size_in  = '0;
            end
            if (req_last_byte) begin
               hit = 1'b1;
               s1_result_in.status = rwcl_pkg::STATUS_NO_DATA;
            end
         end
         default: begin
            hit = 1'b0;
         end
      endcase

      if (hit) begin
         phase_in = rwcl_pkg::PHASE_DONE;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept && hit) begin
         s1_valid_in = 1'b1;
      end else if (res_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= rwcl_pkg::PHASE_HEADER;
         nxt_ff      <= 32'd1;
         hdr_ff      <= 32'(rwcl_pkg::CHUNK_HDR) + 32'd1;
         tag_ff      <= '0;
         size_ff     <= '0;
         skip_ff     <= '0;
         idx_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            nxt_ff   <= nxt_in;
            hdr_ff   <= hdr_in;
            tag_ff   <= tag_in;
            size_ff  <= size_in;
            skip_ff  <= skip_in;
            idx_ff   <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hit) begin
         s1_result_ff <= s1_result_in;
      end
   end

   assign res_valid  = s1_valid_ff;
   assign res_result = s1_result_ff;

`ifndef SYNTHESIS
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !res_ready |=> s1_valid_ff && $stable(s1_result_ff))
      else $error("result dropped or changed while stalled");

   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == rwcl_pkg::PHASE_SKIP |-> skip_ff != '0)
      else $error("skip phase with nothing left to skip");

   a_hdr_track: assert property (@(posedge clock) disable iff (reset)
      hdr_ff == nxt_ff + 32'(rwcl_pkg::CHUNK_HDR))
      else $error("header end lost track of byte position");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && !req_first_byte && phase_ff == rwcl_pkg::PHASE_DONE |-> !hit)
      else $error("second result for one file");
`endif

endmodule

// File: rtl/rwcl_frame_stage.sv
// Output stage: frame count by reciprocal multiply into the result register.
// Depends on rwcl_pkg.
module rwcl_frame_stage #(
   parameter int FRAME_CHANNELS = 2,
   parameter int SAMPLE_BYTES   = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       res_valid,
   output logic                       res_ready,
   input  rwcl_pkg::result_type       res_result,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic [rwcl_pkg::LEN_W-1:0] rsp_data_offset,
   output logic [rwcl_pkg::LEN_W-1:0] rsp_data_size,
   output logic [rwcl_pkg::LEN_W-1:0] rsp_frame_count
);

   localparam int FrameBytes = FRAME_CHANNELS * SAMPLE_BYTES;
   localparam int FrameLog   = $clog2(FrameBytes);
   localparam int Shift      = rwcl_pkg::LEN_W + FrameLog;
   localparam logic [63:0] Recip =
      ((64'd1 << Shift) + 64'(FrameBytes) - 64'd1) / 64'(FrameBytes);
   localparam int ProdW = 72;

   logic                       out_valid_ff;
   rwcl_pkg::result_type       out_result_ff;
   logic [rwcl_pkg::LEN_W-1:0] frames_ff;
   logic [ProdW-1:0]           product;
   logic                       load;

   assign res_ready = !out_valid_ff || rsp_ready;
   assign load      = res_valid && res_ready;
   assign product   = {41'd0, res_result.data_size} * {39'd0, Recip[32:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_ready) begin
         out_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_result_ff <= res_result;
         frames_ff     <= product[Shift +: rwcl_pkg::LEN_W];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_result_ff.status;
   assign rsp_data_offset = out_result_ff.data_offset;
   assign rsp_data_size   = out_result_ff.data_size;
   assign rsp_frame_count = frames_ff;

endmodule
